FILE: rtl/vsi_pkg.sv
// Shared types and codes of the valve safety interlock.
package vsi_pkg;

   // Field widths of the request and response items
   localparam int KIND_W    = 3;
   localparam int CYL_W     = 3;
   localparam int STATE_W   = 3;
   localparam int ERR_W     = 2;
   localparam int OUT_MASK_W = 6;

   // Command kinds
   localparam logic [KIND_W-1:0] KIND_SUPPLY     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXHAUST    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEST       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TOTAL_TEST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALL_OFF    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PERIODIC   = 3'd5;

   // Cylinder states
   localparam logic [STATE_W-1:0] ST_INIT        = 3'd0;
   localparam logic [STATE_W-1:0] ST_WAIT_TEST   = 3'd1;
   localparam logic [STATE_W-1:0] ST_READY       = 3'd2;
   localparam logic [STATE_W-1:0] ST_ACTIVE      = 3'd3;
   localparam logic [STATE_W-1:0] ST_LOW_WARNING = 3'd4;
   localparam logic [STATE_W-1:0] ST_LOW_REPLACE = 3'd5;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_INDEX = 2'd1;
   localparam logic [ERR_W-1:0] ERR_INTERLOCK = 2'd2;
   localparam logic [ERR_W-1:0] ERR_PLATFORM  = 2'd3;

   // One request item
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CYL_W-1:0]   cylinder;
      logic               turn_on;
      logic [STATE_W-1:0] cyl_state;
      logic               qualified;
      logic               auto_mode;
      logic               hw_ok;
   } req_type;

   // Sticky alarm flags
   typedef struct packed {
      logic platform;
      logic interlock;
   } alarm_type;

   // Verdict on one request
   typedef struct packed {
      logic             accepted;
      logic [ERR_W-1:0] error_code;
   } outcome_type;

endpackage

FILE: rtl/vsi_rules.sv
// Interlock rules: evaluates one request against the valve state.
module vsi_rules #(
   parameter int CYLINDERS = 6
) (
   input  vsi_pkg::req_type      cmd,
   input  logic [CYLINDERS-1:0]  sup_mask,
   input  logic [CYLINDERS-1:0]  exh_mask,
   input  logic [CYLINDERS-1:0]  tst_mask,
   input  logic                  total_on,
   input  vsi_pkg::alarm_type    alarm,
   output logic [CYLINDERS-1:0]  sup_mask_in,
   output logic [CYLINDERS-1:0]  exh_mask_in,
   output logic [CYLINDERS-1:0]  tst_mask_in,
   output logic                  total_on_in,
   output vsi_pkg::alarm_type    alarm_in,
   output vsi_pkg::outcome_type  outcome
);
   import vsi_pkg::*;

   localparam logic [CYL_W:0] CYL_LIMIT = (CYL_W+1)'(CYLINDERS);

   logic [CYLINDERS-1:0] sel;
   logic                 in_range;
   logic                 sup_state_ok;
   logic                 sup_conflict;
   logic                 man_ok;
   logic                 refuse;

   // Decode the cylinder index into a one-hot select
   always_comb begin
      for (int i = 0; i < CYLINDERS; i++) begin
         sel[i] = ({1'b0, cmd.cylinder} == (CYL_W+1)'(i));
      end
   end

   assign in_range = ({1'b0, cmd.cylinder} < CYL_LIMIT);

   // Supply open: allowed state, no exhaust or test on this cylinder, no other supply
   assign sup_state_ok = (cmd.cyl_state == ST_READY && cmd.qualified) ||
                         cmd.cyl_state == ST_ACTIVE || cmd.cyl_state == ST_LOW_WARNING;
   assign sup_conflict = (|(exh_mask & sel)) || (|(tst_mask & sel)) ||
                         (|(sup_mask & ~sel));

   // Exhaust or test open: auto mode, allowed state, supply closed
   assign man_ok = cmd.auto_mode && !(|(sup_mask & sel)) &&
                   (cmd.cyl_state == ST_INIT || cmd.cyl_state == ST_WAIT_TEST ||
                    cmd.cyl_state == ST_READY || cmd.cyl_state == ST_LOW_REPLACE);

   // Refuse an open request that breaks the rules
   always_comb begin
      refuse = 1'b0;
      if (cmd.turn_on) begin
         if (cmd.kind == KIND_SUPPLY) begin
            refuse = !sup_state_ok || sup_conflict;
         end else begin
            refuse = !man_ok || (cmd.kind == KIND_TEST && !total_on);
         end
      end
   end

   // Work out the next valve state, alarms and verdict
   always_comb begin
      sup_mask_in = sup_mask;
      exh_mask_in = exh_mask;
      tst_mask_in = tst_mask;
      total_on_in = total_on;
      alarm_in    = alarm;
      outcome.accepted   = 1'b0;
      outcome.error_code = ERR_OK;
      unique case (cmd.kind)
         KIND_SUPPLY, KIND_EXHAUST, KIND_TEST: begin
            if (!in_range) begin
               outcome.error_code = ERR_BAD_INDEX;
            end else if (refuse) begin
               alarm_in.interlock = 1'b1;
               outcome.error_code = ERR_INTERLOCK;
            end else if (!cmd.hw_ok) begin
               alarm_in.platform  = 1'b1;
               outcome.error_code = ERR_PLATFORM;
            end else begin
               outcome.accepted = 1'b1;
               priority if (cmd.kind == KIND_SUPPLY) begin
                  sup_mask_in = cmd.turn_on ? (sup_mask | sel) : (sup_mask & ~sel);
               end else if (cmd.kind == KIND_EXHAUST) begin
                  exh_mask_in = cmd.turn_on ? (exh_mask | sel) : (exh_mask & ~sel);
               end else begin
                  tst_mask_in = cmd.turn_on ? (tst_mask | sel) : (tst_mask & ~sel);
               end
            end
         end
         KIND_TOTAL_TEST: begin
            if (total_on == cmd.turn_on) begin
               outcome.accepted = 1'b1;
            end else if (!cmd.hw_ok) begin
               alarm_in.platform  = 1'b1;
               outcome.error_code = ERR_PLATFORM;
            end else begin
               total_on_in      = cmd.turn_on;
               outcome.accepted = 1'b1;
            end
         end
         KIND_ALL_OFF: begin
            if (!cmd.hw_ok) begin
               alarm_in.platform  = 1'b1;
               outcome.error_code = ERR_PLATFORM;
            end else begin
               sup_mask_in      = '0;
               exh_mask_in      = '0;
               tst_mask_in      = '0;
               total_on_in      = 1'b0;
               outcome.accepted = 1'b1;
            end
         end
         KIND_PERIODIC: begin
            if (!cmd.hw_ok) begin
               alarm_in.platform  = 1'b1;
               outcome.error_code = ERR_PLATFORM;
            end else begin
               outcome.accepted = 1'b1;
            end
         end
         default: begin
            outcome.error_code = ERR_BAD_INDEX;
         end
      endcase
   end

endmodule

FILE: rtl/valve_safety_interlock_core.sv
// Top level of the valve safety interlock: request register, rules, response register.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   kind, cylinder, turn_on, cyl_state,
//                                               qualified, auto_mode, hw_ok
//   rsp_     out        rsp_valid / rsp_ready   accepted, error_code, valve masks,
//                                               total test, alarm flags
//
// One request per cycle sustained while responses are taken; a response is offered once its
// request has passed the request register and then the response register.
// The valve state is updated in the same cycle a request leaves the request register,
// so the next request always sees the result of the one before.
// Reset closes every valve and clears both alarms and both pipeline stages.
// A stalled response holds both stages; req_ready falls only when both are full.
module valve_safety_interlock_core #(
   parameter int CYLINDERS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vsi_pkg::KIND_W-1:0]          req_kind,
   input  logic [vsi_pkg::CYL_W-1:0]           req_cylinder,
   input  logic                                req_turn_on,
   input  logic [vsi_pkg::STATE_W-1:0]         req_cyl_state,
   input  logic                                req_qualified,
   input  logic                                req_auto_mode,
   input  logic                                req_hw_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic [vsi_pkg::ERR_W-1:0]           rsp_error_code,
   output logic [vsi_pkg::OUT_MASK_W-1:0]      rsp_supply_open,
   output logic [vsi_pkg::OUT_MASK_W-1:0]      rsp_exhaust_open,
   output logic [vsi_pkg::OUT_MASK_W-1:0]      rsp_test_open,
   output logic                                rsp_total_test_on,
   output logic                                rsp_alarm_interlock,
   output logic                                rsp_alarm_platform
);
   import vsi_pkg::*;

   req_type              req_ff;
   logic                 req_valid_ff;
   logic                 advance;

   logic [CYLINDERS-1:0] sup_ff, sup_in;
   logic [CYLINDERS-1:0] exh_ff, exh_in;
   logic [CYLINDERS-1:0] tst_ff, tst_in;
   logic                 total_ff, total_in;
   alarm_type            alarm_ff, alarm_in;
   outcome_type          outcome;

   logic [OUT_MASK_W-1:0] sup_out, exh_out, tst_out;

   logic                  rsp_valid_ff;
   outcome_type           rsp_outcome_ff;
   logic [OUT_MASK_W-1:0] rsp_sup_ff, rsp_exh_ff, rsp_tst_ff;
   logic                  rsp_total_ff;
   alarm_type             rsp_alarm_ff;

   // Move the request stage on when the response register is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;

   // Hold the incoming request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.kind      <= req_kind;
         req_ff.cylinder  <= req_cylinder;
         req_ff.turn_on   <= req_turn_on;
         req_ff.cyl_state <= req_cyl_state;
         req_ff.qualified <= req_qualified;
         req_ff.auto_mode <= req_auto_mode;
         req_ff.hw_ok     <= req_hw_ok;
      end
   end

   vsi_rules #(
      .CYLINDERS (CYLINDERS)
   ) u_rules (
      .cmd         (req_ff),
      .sup_mask    (sup_ff),
      .exh_mask    (exh_ff),
      .tst_mask    (tst_ff),
      .total_on    (total_ff),
      .alarm       (alarm_ff),
      .sup_mask_in (sup_in),
      .exh_mask_in (exh_in),
      .tst_mask_in (tst_in),
      .total_on_in (total_in),
      .alarm_in    (alarm_in),
      .outcome     (outcome)
   );

   // Commit the valve state when the request moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         sup_ff   <= '0;
         exh_ff   <= '0;
         tst_ff   <= '0;
         total_ff <= 1'b0;
         alarm_ff <= '0;
      end else if (req_valid_ff && advance) begin
         sup_ff   <= sup_in;
         exh_ff   <= exh_in;
         tst_ff   <= tst_in;
         total_ff <= total_in;
         alarm_ff <= alarm_in;
      end
   end

   // Fit the masks to the six-bit response fields
   generate
      for (genvar i = 0; i < OUT_MASK_W; i++) begin : g_out
         if (i < CYLINDERS) begin : g_used
            assign sup_out[i] = sup_in[i];
            assign exh_out[i] = exh_in[i];
            assign tst_out[i] = tst_in[i];
         end else begin : g_unused
            assign sup_out[i] = 1'b0;
            assign exh_out[i] = 1'b0;
            assign tst_out[i] = 1'b0;
         end
      end
   endgenerate

   // Hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && advance) begin
         rsp_outcome_ff <= outcome;
         rsp_sup_ff     <= sup_out;
         rsp_exh_ff     <= exh_out;
         rsp_tst_ff     <= tst_out;
         rsp_total_ff   <= total_in;
         rsp_alarm_ff   <= alarm_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_outcome_ff.accepted;
   assign rsp_error_code      = rsp_outcome_ff.error_code;
   assign rsp_supply_open     = rsp_sup_ff;
   assign rsp_exhaust_open    = rsp_exh_ff;
   assign rsp_test_open       = rsp_tst_ff;
   assign rsp_total_test_on   = rsp_total_ff;
   assign rsp_alarm_interlock = rsp_alarm_ff.interlock;
   assign rsp_alarm_platform  = rsp_alarm_ff.platform;

endmodule

FILE: rtl/vsi_checker.sv
// Port-level checks of the valve safety interlock and their binding to the top level.
module vsi_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_accepted,
   input logic [vsi_pkg::ERR_W-1:0]      rsp_error_code,
   input logic [vsi_pkg::OUT_MASK_W-1:0] rsp_supply_open,
   input logic [vsi_pkg::OUT_MASK_W-1:0] rsp_exhaust_open,
   input logic [vsi_pkg::OUT_MASK_W-1:0] rsp_test_open,
   input logic                           rsp_alarm_interlock,
   input logic                           rsp_alarm_platform
);
   import vsi_pkg::*;

   logic seen_interlock_ff;
   logic seen_platform_ff;

   // Remember alarms already delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_interlock_ff <= 1'b0;
         seen_platform_ff  <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_interlock_ff <= seen_interlock_ff || rsp_alarm_interlock;
         seen_platform_ff  <= seen_platform_ff || rsp_alarm_platform;
      end
   end

   // Alarms never drop once reported
   a_alarm_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!seen_interlock_ff || rsp_alarm_interlock) &&
                     (!seen_platform_ff || rsp_alarm_platform)))
      else $error("alarm flag cleared after being reported");

   // Accepted exactly when no error is reported
   a_accept_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_error_code == ERR_OK)))
      else $error("accepted flag disagrees with error code");

   // A refusal or failure raises its alarm in the same response
   a_err_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_error_code != ERR_INTERLOCK || rsp_alarm_interlock) &&
                     (rsp_error_code != ERR_PLATFORM || rsp_alarm_platform)))
      else $error("error reported without its alarm");

   // At most one supply open, and never together with exhaust or test on a cylinder
   a_supply_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0(rsp_supply_open) &&
                     ((rsp_supply_open & (rsp_exhaust_open | rsp_test_open)) == '0)))
      else $error("supply interlock broken");

   // A stalled response keeps its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code))
      else $error("stalled response changed");

endmodule

bind valve_safety_interlock_core vsi_checker u_vsi_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_accepted        (rsp_accepted),
   .rsp_error_code      (rsp_error_code),
   .rsp_supply_open     (rsp_supply_open),
   .rsp_exhaust_open    (rsp_exhaust_open),
   .rsp_test_open       (rsp_test_open),
   .rsp_alarm_interlock (rsp_alarm_interlock),
   .rsp_alarm_platform  (rsp_alarm_platform)
);
